// File: rtl/core/rlps_pkg.sv
`default_nettype none

package rlps_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DESC_W = 64;

    // input opcodes (s_axis tuser)
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // result kinds (m_axis tuser)
    localparam logic [1:0] KIND_SENT   = 2'd0;
    localparam logic [1:0] KIND_STALE  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // config register indexes
    localparam logic [1:0] REG_BYTE_BUDGET = 2'd0;
    localparam logic [1:0] REG_WINDOW_MS   = 2'd1;
    localparam logic [1:0] REG_MAX_AGE_MS  = 2'd2;

    localparam logic [31:0] RST_BYTE_BUDGET = 32'd0;
    localparam logic [15:0] RST_WINDOW_MS   = 16'd1000;
    localparam logic [15:0] RST_MAX_AGE_MS  = 16'd5000;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] len;
        logic [31:0] stamp;
    } t_desc;

    // shared unit: res = a +/- b, then res compared against c
    typedef struct packed {
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        carry;
        logic        ge;
        logic        gt;
    } t_alu_rsp;

endpackage

`default_nettype wire

// File: rtl/core/rate_limited_priority_scheduler.sv
// Strict-priority descriptor scheduler with a per-window byte limit.
// s_axis: one word per command. tuser = opcode (enqueue+drain, tick, drain).
//   tdata[2:0] prio, [18:3] pkt_length, [34:19] pkt_tag, rest zero.
// m_axis: one word per result. tuser = kind (sent, stale, reject, done);
//   tdata[2:0] out_prio, [18:3] out_length, [34:19] out_tag; tlast marks
//   the done word that closes every command.
// cfg: index/data write channel, always ready; write only while idle.
// Timing: a small sequencer drives one shared add/compare unit, so one
//   command is in flight at a time and s_axis_tready is low until its done
//   word has been loaded. Tick: S_TICK, S_DONE. Drain: S_WIN and S_BUD check
//   window and budget (S_BUD skipped if unlimited), S_SCAN per empty queue,
//   and per descriptor S_SCAN, S_RD, S_EMIT, plus S_ACC, S_CHK when sent (no
//   S_CHK if unlimited); S_SCAN reads memory. Enqueue adds S_ENQ (+S_REJ).
// The result register lets the sequencer run on while a word waits;
//   a stall on m_axis holds the sequencer at the next emit step.
// Reset (sync, active low) empties all queues, clears the clock and byte
//   window and reloads the register defaults; the queue memory is not
//   cleared and needs no sweep.
`default_nettype none

module rate_limited_priority_scheduler
    import rlps_pkg::*;
#(
    parameter int unsigned NUM_PRIOS   = 5,
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // command in
    input  var logic        i_s_axis_tvalid,
    output var logic        o_s_axis_tready,
    input  var logic [39:0] i_s_axis_tdata,  // prio, pkt_length, pkt_tag
    input  var logic [1:0]  i_s_axis_tuser,  // opcode
    // results out
    output var logic        o_m_axis_tvalid,
    input  var logic        i_m_axis_tready,
    output var logic [39:0] o_m_axis_tdata,  // out_prio, out_length, out_tag
    output var logic [1:0]  o_m_axis_tuser,  // kind
    output var logic        o_m_axis_tlast,
    // config writes
    input  var logic        i_cfg_valid,
    output var logic        o_cfg_ready,
    input  var logic [1:0]  i_cfg_index,
    input  var logic [31:0] i_cfg_data
);

    localparam int unsigned TOTAL = NUM_PRIOS * QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(TOTAL);
    localparam int unsigned PW    = $clog2(NUM_PRIOS);
    localparam int unsigned QW    = $clog2(NUM_PRIOS + 1);
    localparam int unsigned HW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_ENQ  = 12'b0000_0000_0010,
        S_REJ  = 12'b0000_0000_0100,
        S_TICK = 12'b0000_0000_1000,
        S_WIN  = 12'b0000_0001_0000,
        S_BUD  = 12'b0000_0010_0000,
        S_SCAN = 12'b0000_0100_0000,
        S_RD   = 12'b0000_1000_0000,
        S_EMIT = 12'b0001_0000_0000,
        S_ACC  = 12'b0010_0000_0000,
        S_CHK  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [31:0] r_budget;
    logic [15:0] r_window;
    logic [15:0] r_max_age;

    // command latch
    logic [1:0]  r_op;
    logic [2:0]  r_prio, n_prio;
    logic        r_prio_ok, n_prio_ok;
    logic [15:0] r_len, n_len;
    logic [15:0] r_tag, n_tag;

    // scheduler state
    logic [QW-1:0] r_q, n_q;
    logic [HW-1:0] r_head  [NUM_PRIOS];
    logic [HW-1:0] n_head  [NUM_PRIOS];
    logic [CW-1:0] r_count [NUM_PRIOS];
    logic [CW-1:0] n_count [NUM_PRIOS];
    logic [31:0]   r_now, n_now;
    logic [31:0]   r_wstart, n_wstart;
    logic [31:0]   r_bytes, n_bytes;
    logic          r_stale, n_stale;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_kind, n_out_kind;
    logic [2:0]  r_out_prio, n_out_prio;
    logic [15:0] r_out_len, n_out_len;
    logic [15:0] r_out_tag, n_out_tag;
    logic        r_out_last, n_out_last;

    logic          out_free;
    logic [PW-1:0] qi;
    logic [HW-1:0] head_cur;
    logic [CW-1:0] cnt_cur;
    logic [AW-1:0] base;
    logic [CW:0]   pos_sum;
    logic [HW-1:0] tail_pos;
    logic [HW-1:0] head_nxt;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_desc         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_desc         mem_rdata;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    rlps_qmem #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rlps_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign out_free = ~r_out_valid | i_m_axis_tready;

    // per-queue view at the current queue index
    assign qi       = r_q[PW-1:0];
    assign head_cur = r_head[qi];
    assign cnt_cur  = r_count[qi];
    assign base     = AW'(int'(qi) * QUEUE_DEPTH);
    assign pos_sum  = (CW+1)'(head_cur) + (CW+1)'(cnt_cur);
    assign tail_pos = (pos_sum >= (CW+1)'(QUEUE_DEPTH))
                    ? HW'(pos_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
    assign head_nxt = ((CW+1)'(head_cur) + (CW+1)'(1) == (CW+1)'(QUEUE_DEPTH))
                    ? '0 : HW'((CW+1)'(head_cur) + (CW+1)'(1));

    assign mem_waddr       = base + AW'(tail_pos);
    assign mem_wdata.tag   = r_tag;
    assign mem_wdata.len   = r_len;
    assign mem_wdata.stamp = r_now;
    assign mem_raddr       = base + AW'(head_cur);

    // shared unit operand select
    always_comb begin
        alu_req.sub = 1'b0;
        alu_req.a   = r_bytes;
        alu_req.b   = '0;
        alu_req.c   = r_budget;
        case (r_state)
            S_TICK: begin
                alu_req.a = r_now;
                alu_req.b = 32'd1;
            end
            S_WIN: begin        // elapsed = now - window_start >= window
                alu_req.sub = 1'b1;
                alu_req.a   = r_now;
                alu_req.b   = r_wstart;
                alu_req.c   = {16'd0, r_window};
            end
            S_RD: begin         // age = now - stamp > max_age
                alu_req.sub = 1'b1;
                alu_req.a   = r_now;
                alu_req.b   = mem_rdata.stamp;
                alu_req.c   = {16'd0, r_max_age};
            end
            S_ACC: begin
                alu_req.b = {16'd0, mem_rdata.len};
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_prio      = r_prio;
        n_prio_ok   = r_prio_ok;
        n_len       = r_len;
        n_tag       = r_tag;
        n_q         = r_q;
        n_head      = r_head;
        n_count     = r_count;
        n_now       = r_now;
        n_wstart    = r_wstart;
        n_bytes     = r_bytes;
        n_stale     = r_stale;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_prio  = r_out_prio;
        n_out_len   = r_out_len;
        n_out_tag   = r_out_tag;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_prio    = i_s_axis_tdata[2:0];
                    n_len     = i_s_axis_tdata[18:3];
                    n_tag     = i_s_axis_tdata[34:19];
                    n_prio_ok = 32'(i_s_axis_tdata[2:0]) < NUM_PRIOS;
                    n_q       = n_prio_ok ? QW'(i_s_axis_tdata[2:0]) : '0;
                    case (i_s_axis_tuser)
                        OP_ENQ:   n_state = S_ENQ;
                        OP_TICK:  n_state = S_TICK;
                        OP_DRAIN: n_state = S_WIN;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ENQ: begin
                if (r_prio_ok && cnt_cur != CW'(QUEUE_DEPTH)) begin
                    mem_we         = 1'b1;
                    n_count[qi]    = cnt_cur + CW'(1);
                    n_state        = S_WIN;
                end else begin
                    n_state = S_REJ;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_REJECT;
                    n_out_prio  = r_prio;
                    n_out_len   = r_len;
                    n_out_tag   = r_tag;
                    n_out_last  = 1'b0;
                    n_state     = S_WIN;
                end
            end
            S_TICK: begin
                n_now   = alu_rsp.res;
                n_state = S_DONE;
            end
            S_WIN: begin
                n_q = '0;
                if (r_budget == '0) begin
                    n_state = S_SCAN;
                end else begin
                    if (alu_rsp.ge) begin
                        n_bytes  = '0;
                        n_wstart = r_now;
                    end
                    n_state = S_BUD;
                end
            end
            S_BUD: begin
                n_state = alu_rsp.ge ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (r_q == QW'(NUM_PRIOS)) begin
                    n_state = S_DONE;
                end else if (cnt_cur == '0) begin
                    n_q = r_q + QW'(1);
                end else begin
                    mem_re      = 1'b1;
                    n_head[qi]  = head_nxt;
                    n_count[qi] = cnt_cur - CW'(1);
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                n_stale = alu_rsp.gt;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_stale ? KIND_STALE : KIND_SENT;
                    n_out_prio  = 3'(r_q);
                    n_out_len   = mem_rdata.len;
                    n_out_tag   = mem_rdata.tag;
                    n_out_last  = 1'b0;
                    n_state     = r_stale ? S_SCAN : S_ACC;
                end
            end
            S_ACC: begin
                // saturating byte count
                n_bytes = alu_rsp.carry ? '1 : alu_rsp.res;
                n_state = (r_budget != '0) ? S_CHK : S_SCAN;
            end
            S_CHK: begin
                n_state = alu_rsp.ge ? S_DONE : S_SCAN;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DONE;
                    n_out_prio  = '0;
                    n_out_len   = '0;
                    n_out_tag   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_wstart    <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PRIOS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_wstart    <= n_wstart;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_count     <= n_count;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_op <= i_s_axis_tuser;
        end
        r_prio     <= n_prio;
        r_prio_ok  <= n_prio_ok;
        r_len      <= n_len;
        r_tag      <= n_tag;
        r_q        <= n_q;
        r_stale    <= n_stale;
        r_out_kind <= n_out_kind;
        r_out_prio <= n_out_prio;
        r_out_len  <= n_out_len;
        r_out_tag  <= n_out_tag;
        r_out_last <= n_out_last;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget  <= RST_BYTE_BUDGET;
            r_window  <= RST_WINDOW_MS;
            r_max_age <= RST_MAX_AGE_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BYTE_BUDGET: r_budget  <= i_cfg_data;
                REG_WINDOW_MS:   r_window  <= i_cfg_data[15:0];
                REG_MAX_AGE_MS:  r_max_age <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_tag, r_out_len, r_out_prio};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // a command holds the sequencer: no second word right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second command accepted while busy");

    // done word closes the command and carries no descriptor
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tuser == KIND_DONE && o_m_axis_tdata == '0))
        else $error("done word malformed");

    // enqueue writes only into a queue with room
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_prio_ok && cnt_cur < CW'(QUEUE_DEPTH)))
        else $error("write into full queue");

    // a descriptor read only comes from a non-empty queue
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> (r_state == S_RD && $past(cnt_cur) != '0))
        else $error("read from empty queue");

    // the command opcode stays put while the command runs
    a_op_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> $stable(r_op))
        else $error("opcode changed mid-command");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rlps_alu.sv
`default_nettype none

module rlps_alu
    import rlps_pkg::*;
(
    input  var t_alu_req i_req,
    output var t_alu_rsp o_rsp
);

    logic [32:0] sum;
    logic [32:0] cmp;

    always_comb begin
        sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
            + {32'd0, i_req.sub};
        cmp = {1'b0, sum[31:0]} - {1'b0, i_req.c};
        o_rsp.res   = sum[31:0];
        o_rsp.carry = sum[32];
        o_rsp.ge    = ~cmp[32];
        o_rsp.gt    = ~cmp[32] && (sum[31:0] != i_req.c);
    end

endmodule

`default_nettype wire

// File: rtl/core/rlps_qmem.sv
`default_nettype none

module rlps_qmem
    import rlps_pkg::*;
#(
    parameter int unsigned DEPTH = 40,
    parameter int unsigned AW    = 6
) (
    input  var logic          i_clk,
    input  var logic          i_we,
    input  var logic [AW-1:0] i_waddr,
    input  var t_desc         i_wdata,
    input  var logic          i_re,
    input  var logic [AW-1:0] i_raddr,
    output var t_desc         o_rdata
);

    t_desc mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_rate_limited_priority_scheduler.sv
`default_nettype none

module tb_rate_limited_priority_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import rlps_pkg::*;

    localparam int unsigned NUM_PRIOS   = 5;
    localparam int unsigned QUEUE_DEPTH = 8;
    // opcode 3 has no meaning: the block only answers with a done word
    localparam logic [1:0]  OP_NONE     = 2'd3;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 60;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_SHOWN   = 10;

    // one result word as the scheduler reports it
    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  prio;
        logic [15:0] len;
        logic [15:0] tag;
        logic        last;
    } t_sched_word;

    // ------------------------------------------------------------------
    // Scoreboard: private copy of the queues, the ms clock and the byte
    // window; every accepted command is turned into the words it must
    // produce, and each word seen on m_axis is matched against the oldest.
    // ------------------------------------------------------------------
    class t_sched_scoreboard;
        t_desc       slots [NUM_PRIOS*QUEUE_DEPTH];
        int unsigned head  [NUM_PRIOS];
        int unsigned count [NUM_PRIOS];
        logic [31:0] now_ms;
        logic [31:0] win_start;
        logic [31:0] win_bytes;
        logic [31:0] budget;
        logic [31:0] window_len;
        logic [31:0] age_limit;
        t_sched_word pending_words [$];
        int          failures;

        function void reset_state();
            for (int p = 0; p < NUM_PRIOS; p++) begin
                head[p]  = 0;
                count[p] = 0;
            end
            now_ms     = '0;
            win_start  = '0;
            win_bytes  = '0;
            budget     = {16'h0, RST_BYTE_BUDGET[15:0]} | RST_BYTE_BUDGET;
            window_len = {16'h0, RST_WINDOW_MS};
            age_limit  = {16'h0, RST_MAX_AGE_MS};
            pending_words.delete();
            failures   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_BYTE_BUDGET: budget     = val;
                REG_WINDOW_MS:   window_len = {16'h0, val[15:0]};
                REG_MAX_AGE_MS:  age_limit  = {16'h0, val[15:0]};
                default: ;
            endcase
        endfunction

        function void push_word(logic [1:0] kind, logic [2:0] prio, logic [15:0] len,
                                logic [15:0] tag, logic last);
            t_sched_word w;
            w.kind = kind;
            w.prio = prio;
            w.len  = len;
            w.tag  = tag;
            w.last = last;
            pending_words.insert(pending_words.size(), w);
        endfunction

        function string word_text(t_sched_word w);
            return $sformatf("kind=%0d prio=%0d len=%0d tag=%0d last=%0d",
                             w.kind, w.prio, w.len, w.tag, w.last);
        endfunction

        // strict-priority pass over the queues under the byte window
        function void predict_drain();
            t_desc       d;
            logic [31:0] age;
            if (budget != 0) begin
                if (now_ms - win_start >= window_len) begin
                    win_bytes = '0;
                    win_start = now_ms;
                end
                if (win_bytes >= budget)
                    return;
            end
            for (int p = 0; p < NUM_PRIOS; p++) begin
                while (count[p] != 0) begin
                    d = slots[p*QUEUE_DEPTH + head[p]];
                    head[p]  = (head[p] + 1) % QUEUE_DEPTH;
                    count[p] = count[p] - 1;
                    age = now_ms - d.stamp;
                    if (age > age_limit) begin
                        push_word(KIND_STALE, p[2:0], d.len, d.tag, 1'b0);
                        continue;
                    end
                    push_word(KIND_SENT, p[2:0], d.len, d.tag, 1'b0);
                    // byte counter sticks at all ones
                    if (win_bytes > 32'hFFFF_FFFF - {16'h0, d.len})
                        win_bytes = 32'hFFFF_FFFF;
                    else
                        win_bytes = win_bytes + {16'h0, d.len};
                    if (budget != 0 && win_bytes >= budget)
                        return;
                end
            end
        endfunction

        function void note_command(logic [1:0] op, logic [2:0] prio, logic [15:0] len,
                                   logic [15:0] tag);
            int unsigned pos;
            case (op)
                OP_ENQ: begin
                    if (prio < NUM_PRIOS && count[prio] < QUEUE_DEPTH) begin
                        pos = (head[prio] + count[prio]) % QUEUE_DEPTH;
                        slots[prio*QUEUE_DEPTH + pos].tag   = tag;
                        slots[prio*QUEUE_DEPTH + pos].len   = len;
                        slots[prio*QUEUE_DEPTH + pos].stamp = now_ms;
                        count[prio] = count[prio] + 1;
                    end else begin
                        push_word(KIND_REJECT, prio, len, tag, 1'b0);
                    end
                    predict_drain();
                end
                OP_TICK:  now_ms = now_ms + 1;
                OP_DRAIN: predict_drain();
                default: ;
            endcase
            push_word(KIND_DONE, 3'd0, 16'd0, 16'd0, 1'b1);
        endfunction

        function void check_word(logic [1:0] kind, logic [39:0] data, logic last);
            t_sched_word want;
            t_sched_word got;
            got.kind = kind;
            got.prio = data[2:0];
            got.len  = data[18:3];
            got.tag  = data[34:19];
            got.last = last;
            if (pending_words.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: unexpected word %s", $realtime, word_text(got));
                return;
            end
            want = pending_words[0];
            pending_words.delete(0);
            if (want.kind !== got.kind || want.prio !== got.prio || want.len !== got.len ||
                want.tag !== got.tag || want.last !== got.last) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: mismatch exp %s, got %s",
                             $realtime, word_text(want), word_text(got));
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // prio, pkt_length, pkt_tag
    logic [1:0]  i_s_axis_tuser;   // opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // out_prio, out_length, out_tag
    logic [1:0]  o_m_axis_tuser;   // kind
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    rate_limited_priority_scheduler #(
        .NUM_PRIOS   (NUM_PRIOS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_sched_scoreboard sb;

    // no idling on either side once set (final phase)
    bit quiet;
    // bumped by the stimulus to ask the result side for one long hold-off
    int hold_asks;

    always #5 i_clk = ~i_clk;

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        quiet           = 1'b0;
        hold_asks       = 0;
        sb              = new();
        sb.reset_state();
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure bursts, plus a long hold-off on
    // request so the block backs up and stalls its command input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        int hold_left;
        int hold_seen;
        gap       = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    // ------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------

    // tvalid stays up between back-to-back words; it only drops for a gap
    task automatic issue(input logic [1:0] op, input logic [2:0] prio,
                         input logic [15:0] len, input logic [15:0] tag);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'b0, tag, len, prio};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_command(op, prio, len, tag);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every predicted word has come back;
    // the done word closes each command, so the block is idle then
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // all three registers, one word each, valid held across them
    task automatic set_regs(input logic [31:0] budget, input logic [15:0] win,
                            input logic [15:0] age);
        logic [31:0] vals [3];
        logic [1:0]  idx  [3];
        vals[0] = budget;          idx[0] = REG_BYTE_BUDGET;
        vals[1] = {16'h0, win};    idx[1] = REG_WINDOW_MS;
        vals[2] = {16'h0, age};    idx[2] = REG_MAX_AGE_MS;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly enqueues so queues build up behind the byte limit; ticks age
    // the heads and roll the window; a few bad prios and dead opcodes
    task automatic random_item();
        int          r;
        logic [1:0]  op;
        logic [2:0]  prio;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        if (r < 55)
            op = OP_ENQ;
        else if (r < 78)
            op = OP_TICK;
        else if (r < 95)
            op = OP_DRAIN;
        else
            op = OP_NONE;
        prio = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(NUM_PRIOS, 7))
                                            : 3'($urandom_range(0, NUM_PRIOS - 1));
        len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 400));
        issue(op, prio, len, 16'($urandom_range(0, 65535)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] budget;
        logic [15:0] win;
        logic [15:0] age;
        int          spins;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, reset registers: no byte limit ---
        issue(OP_ENQ, 3'd0, 16'h0000, 16'h0000);
        issue(OP_ENQ, 3'd4, 16'hFFFF, 16'hFFFF);
        for (int p = 1; p < 4; p++)
            issue(OP_ENQ, p[2:0], 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        // prio past the last queue is turned away like a full queue
        for (int p = NUM_PRIOS; p < 8; p++)
            issue(OP_ENQ, p[2:0], 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        issue(OP_DRAIN, 3'd7, 16'hFFFF, 16'hFFFF);
        issue(OP_TICK, 3'd0, 16'h0, 16'h0);
        issue(OP_NONE, 3'd5, 16'h1234, 16'hABCD);
        wait_idle();

        // --- directed, tightest limits: budget spent by one word, queue
        //     fills and rejects, then everything goes stale ---
        set_regs(32'd1, 16'd1, 16'd1);
        issue(OP_ENQ, 3'd2, 16'd5, 16'h0F0F);
        for (int k = 0; k < QUEUE_DEPTH + 1; k++)
            issue(OP_ENQ, 3'd0, 16'($urandom_range(1, 100)),
                  16'($urandom_range(0, 65535)));
        issue(OP_TICK, 3'd0, 16'h0, 16'h0);
        issue(OP_TICK, 3'd0, 16'h0, 16'h0);
        issue(OP_DRAIN, 3'd0, 16'h0, 16'h0);
        wait_idle();

        // --- random phases, each under its own register setting ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin budget = 32'd0;          win = 16'd65535; age = 16'd65535; end
                1: begin budget = 32'hFFFF_FFFF;  win = 16'd1;     age = 16'd1;     end
                2: begin
                    budget = $urandom_range(1, 3000);
                    win    = 16'($urandom_range(1, 16));
                    age    = 16'($urandom_range(2, 40));
                end
                // zero window: every drain with a budget opens a new window
                3: begin
                    budget = $urandom_range(1, 300);
                    win    = 16'd0;
                    age    = 16'($urandom_range(1, 20));
                end
                default: begin
                    budget = ($urandom_range(0, 4) == 0) ? $urandom
                                                         : $urandom_range(1, 1500);
                    win    = 16'($urandom_range(1, 12));
                    age    = 16'($urandom_range(1, 30));
                end
            endcase
            // last phase runs with the result side always ready and no sender gaps
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            set_regs(budget, win, age);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 20)
                    hold_asks++;
                // sender pause mid-phase until the block has caught up
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    wait_idle();
                random_item();
            end
            wait_idle();
        end

        // bounded final drain; wait_idle already ran, this only guards
        i_s_axis_tvalid <= 1'b0;
        spins = 0;
        while (sb.pending() != 0 && spins < 100000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (20) @(negedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS rate_limited_priority_scheduler");
        end else begin
            $display("FAIL rate_limited_priority_scheduler");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin : watchdog
        #15ms;
        $display("FAIL rate_limited_priority_scheduler");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/rlps_pkg.sv
rtl/core/rlps_alu.sv
rtl/core/rlps_qmem.sv
rtl/core/rate_limited_priority_scheduler.sv
tb/tb_rate_limited_priority_scheduler.sv
